// File: design/rgb_to_hls_converter_defines.svh
// Assertion macros for the RGB to HLS converter.
`ifndef RGB_TO_HLS_CONVERTER_DEFINES_SVH
`define RGB_TO_HLS_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/rgbhls_pkg.sv
package rgbhls_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 9;
    localparam int QUO_W      = 13;
    localparam int NUM_W      = 21;
    localparam int DIFF_W     = 9;
    localparam int SIX_W      = 12;
    localparam int PROD_W     = 23;
    localparam int SAT_FRAC_W = 12;

    localparam int HUE_SEXTANT = 960;
    localparam int HUE_TURN    = 5760;
    localparam int SAT_ONE     = 4096;
    localparam int SUM_HALF    = 255;
    localparam int SUM_FULL    = 510;

    // request accepted to strobe, in clock edges
    localparam int LATENCY = 17;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pixel;

    typedef struct packed {
        logic [QUO_W-1:0] hue_out;
        logic [SUM_W-1:0] light_sum;
        logic [QUO_W-1:0] sat_out;
    } t_hls;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

endpackage

// File: design/rgb_to_hls_converter.sv
// RGB to HLS converter, fully pipelined: two restoring dividers, one quotient bit per stage.
// A request passes the stage-1, stage-2 and divider-head registers, then the divider stages and the output register.
// Throughput: one pixel per clock; busy is low whenever reset is released.
// Reset (i_rst_n, synchronous, active low) drops every request in flight; busy is high in reset.
// The receiver cannot stall: o_valid marks each result for exactly one cycle.
`include "rgb_to_hls_converter_defines.svh"

module rgb_to_hls_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rgbhls_pkg::t_pixel    i_pixel,
    output logic                  o_valid,
    output rgbhls_pkg::t_hls      o_result
);

    typedef struct packed {
        logic                                valid;
        logic                                chroma;
        rgbhls_pkg::t_max_sel                sel;
        logic [rgbhls_pkg::SUM_W-1:0]        sum;
        logic [rgbhls_pkg::PIX_W-1:0]        delta;
        logic signed [rgbhls_pkg::DIFF_W-1:0] diff;
    } t_s1;

    typedef struct packed {
        logic                                valid;
        logic                                chroma;
        logic [rgbhls_pkg::SUM_W-1:0]        sum;
        logic [rgbhls_pkg::PIX_W-1:0]        delta;
        logic [rgbhls_pkg::PIX_W-1:0]        denom;
        logic signed [rgbhls_pkg::SIX_W-1:0] sixths;
    } t_s2;

    typedef struct packed {
        logic                                valid;
        logic                                chroma;
        logic [rgbhls_pkg::SUM_W-1:0]        sum;
        logic [rgbhls_pkg::PIX_W-1:0]        delta;
        logic [rgbhls_pkg::PIX_W-1:0]        denom;
        logic [rgbhls_pkg::NUM_W-1:0]        hue_rem;
        logic [rgbhls_pkg::QUO_W-1:0]        hue_q;
        logic [rgbhls_pkg::NUM_W-1:0]        sat_rem;
        logic [rgbhls_pkg::QUO_W-1:0]        sat_q;
    } t_div;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_div n_head;
    t_div r_div [0:rgbhls_pkg::QUO_W];
    t_div n_div [0:rgbhls_pkg::QUO_W];
    logic r_valid;
    rgbhls_pkg::t_hls r_result, n_result;

    logic accept;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // stage 1: max, min, sum, spread and the dominant channel
    always_comb begin
        logic [rgbhls_pkg::PIX_W-1:0] r, g, b, mx, mn;
        r = i_pixel.red_in;
        g = i_pixel.green_in;
        b = i_pixel.blue_in;
        n_s1 = '0;
        n_s1.valid = accept;
        if (r >= g && r >= b) begin
            n_s1.sel  = rgbhls_pkg::MAX_RED;
            mx        = r;
            n_s1.diff = $signed({1'b0, g}) - $signed({1'b0, b});
        end else if (g >= b) begin
            n_s1.sel  = rgbhls_pkg::MAX_GREEN;
            mx        = g;
            n_s1.diff = $signed({1'b0, b}) - $signed({1'b0, r});
        end else begin
            n_s1.sel  = rgbhls_pkg::MAX_BLUE;
            mx        = b;
            n_s1.diff = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
        n_s1.sum    = {1'b0, mx} + {1'b0, mn};
        n_s1.delta  = mx - mn;
        n_s1.chroma = (mx != mn);
    end

    // stage 2: saturation divisor and hue numerator in sextant units
    always_comb begin
        logic signed [rgbhls_pkg::SIX_W-1:0] base;
        n_s2 = '0;
        n_s2.valid  = r_s1.valid;
        n_s2.chroma = r_s1.chroma;
        n_s2.sum    = r_s1.sum;
        n_s2.delta  = r_s1.delta;
        if (r_s1.sum < rgbhls_pkg::SUM_W'(rgbhls_pkg::SUM_HALF)) begin
            n_s2.denom = r_s1.sum[rgbhls_pkg::PIX_W-1:0];
        end else begin
            n_s2.denom = rgbhls_pkg::PIX_W'(rgbhls_pkg::SUM_W'(rgbhls_pkg::SUM_FULL) - r_s1.sum);
        end
        case (r_s1.sel)
            rgbhls_pkg::MAX_GREEN: base = $signed(rgbhls_pkg::SIX_W'({r_s1.delta, 1'b0}));
            rgbhls_pkg::MAX_BLUE:  base = $signed(rgbhls_pkg::SIX_W'({r_s1.delta, 2'b00}));
            default:               base = '0;
        endcase
        n_s2.sixths = base + rgbhls_pkg::SIX_W'(r_s1.diff);
    end

    // stage 3: scale hue to sixteenths of a degree and wrap negative angles
    always_comb begin
        logic signed [rgbhls_pkg::PROD_W-1:0] prod;
        prod = (rgbhls_pkg::PROD_W'(r_s2.sixths) <<< 10)
             - (rgbhls_pkg::PROD_W'(r_s2.sixths) <<< 6);
        if (prod < 0) begin
            prod = prod + $signed(rgbhls_pkg::PROD_W'(r_s2.delta)
                                  * rgbhls_pkg::PROD_W'(rgbhls_pkg::HUE_TURN));
        end
        n_head = '0;
        n_head.valid   = r_s2.valid;
        n_head.chroma  = r_s2.chroma;
        n_head.sum     = r_s2.sum;
        n_head.delta   = r_s2.delta;
        n_head.denom   = r_s2.denom;
        n_head.hue_rem = prod[rgbhls_pkg::NUM_W-1:0];
        n_head.sat_rem = rgbhls_pkg::NUM_W'({r_s2.delta, {rgbhls_pkg::SAT_FRAC_W{1'b0}}});
    end

    // divider stages: one quotient bit each, most significant first
    always_comb begin
        logic [rgbhls_pkg::NUM_W-1:0] hue_dsh, sat_dsh;
        n_div[0] = n_head;
        for (int k = 0; k < rgbhls_pkg::QUO_W; k++) begin
            n_div[k+1] = r_div[k];
            hue_dsh = rgbhls_pkg::NUM_W'(r_div[k].delta) << (rgbhls_pkg::QUO_W - 1 - k);
            sat_dsh = rgbhls_pkg::NUM_W'(r_div[k].denom) << (rgbhls_pkg::QUO_W - 1 - k);
            if (r_div[k].hue_rem >= hue_dsh) begin
                n_div[k+1].hue_rem = r_div[k].hue_rem - hue_dsh;
                n_div[k+1].hue_q[rgbhls_pkg::QUO_W-1-k] = 1'b1;
            end
            if (r_div[k].sat_rem >= sat_dsh) begin
                n_div[k+1].sat_rem = r_div[k].sat_rem - sat_dsh;
                n_div[k+1].sat_q[rgbhls_pkg::QUO_W-1-k] = 1'b1;
            end
        end
    end

    // output: zero hue and saturation for gray pixels
    always_comb begin
        n_result.light_sum = r_div[rgbhls_pkg::QUO_W].sum;
        n_result.hue_out   = r_div[rgbhls_pkg::QUO_W].chroma ? r_div[rgbhls_pkg::QUO_W].hue_q : '0;
        n_result.sat_out   = r_div[rgbhls_pkg::QUO_W].chroma ? r_div[rgbhls_pkg::QUO_W].sat_q : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            for (int k = 0; k <= rgbhls_pkg::QUO_W; k++) begin
                r_div[k].valid <= 1'b0;
            end
            r_valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            for (int k = 0; k <= rgbhls_pkg::QUO_W; k++) begin
                r_div[k] <= n_div[k];
            end
            r_valid <= r_div[rgbhls_pkg::QUO_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `RHC_ASSERT(a_latency, i_clk, i_rst_n,
        accept |-> ##(rgbhls_pkg::LATENCY) o_valid, "request lost in pipeline")
    `RHC_ASSERT(a_range, i_clk, i_rst_n,
        o_valid |-> (o_result.hue_out < rgbhls_pkg::QUO_W'(rgbhls_pkg::HUE_TURN)
                     && o_result.sat_out <= rgbhls_pkg::QUO_W'(rgbhls_pkg::SAT_ONE)),
        "result out of range")
    `RHC_ASSERT(a_gray, i_clk, i_rst_n,
        (o_valid && o_result.sat_out == '0) |-> (o_result.hue_out == '0),
        "gray pixel with nonzero hue")
    `RHC_ASSERT(a_spread, i_clk, i_rst_n,
        (r_s1.valid && r_s1.chroma) |-> (r_s1.delta != '0 && r_s1.sum != '0),
        "chromatic pixel with zero divisor")
    `RHC_ASSERT_ALWAYS(a_busy_rst, i_clk, (!i_rst_n) |-> busy, "request taken in reset")

endmodule
